>>> design/bbc_pkg.sv
package bbc_pkg;

	// Default cache size
	localparam int NUM_BUFFERS_DEF = 32;

	// Slot flag bit positions
	localparam int FLAG_W     = 5;
	localparam int FB_BUSY    = 0;
	localparam int FB_INVAL   = 1;
	localparam int FB_DONE    = 2;
	localparam int FB_DIRTY   = 3;
	localparam int FB_READ    = 4;
	localparam logic [FLAG_W-1:0] FLAGS_RESET = 5'b00010;
	localparam logic [FLAG_W-1:0] FLAGS_BUSY  = 5'b00001;

	// Operation codes
	localparam logic [2:0] OP_GET        = 3'd0;
	localparam logic [2:0] OP_RELEASE    = 3'd1;
	localparam logic [2:0] OP_READ_DONE  = 3'd2;
	localparam logic [2:0] OP_DELAYED_WR = 3'd3;
	localparam logic [2:0] OP_WRITE_DONE = 3'd4;

	// Status codes
	localparam logic [2:0] ST_HIT       = 3'd0;
	localparam logic [2:0] ST_MISS      = 3'd1;
	localparam logic [2:0] ST_BUSY      = 3'd2;
	localparam logic [2:0] ST_WRITEBACK = 3'd3;
	localparam logic [2:0] ST_NOFREE    = 3'd4;
	localparam logic [2:0] ST_DONE      = 3'd5;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] device_id;
		logic [30:0] block_number;
		logic [4:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  granted_slot;
		logic        data_valid;
		logic [15:0] victim_device;
		logic [30:0] victim_block;
	} rsp_t;

	// Free list operations
	typedef enum logic [1:0] {
		LOP_NONE,
		LOP_TAKE,
		LOP_HEAD,
		LOP_TAIL
	} lop_t;

	// Slot update carried to the slot cells
	typedef struct packed {
		logic              flag_we;
		logic              tag_we;
		logic [FLAG_W-1:0] flags;
	} flag_upd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_DECIDE,
		S_APPLY
	} state_t;

endpackage

>>> design/bbc_slot_cell.sv
module bbc_slot_cell #(
	parameter int SW  = 5,
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       look_en,
	input  logic [15:0]                key_dev,
	input  logic [30:0]                key_blk,
	input  logic                       upd_en,
	input  logic [SW-1:0]              upd_slot,
	input  bbc_pkg::flag_upd_t         upd,
	input  logic                       seen_in,
	output logic                       seen_out,
	output logic                       first,
	output logic [bbc_pkg::FLAG_W-1:0] flags,
	output logic [15:0]                tag_dev,
	output logic [30:0]                tag_blk
);

	logic [bbc_pkg::FLAG_W-1:0] flags_q;
	logic [15:0]                dev_q;
	logic [30:0]                blk_q;
	logic                       match_q;
	logic                       sel;

	assign sel = upd_en && (upd_slot == SW'(IDX));

	// Flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= bbc_pkg::FLAGS_RESET;
		end else if (sel && upd.flag_we) begin
			flags_q <= upd.flags;
		end
	end

	// Tag store, written on a clean miss
	always_ff @(posedge clk) begin
		if (sel && upd.tag_we) begin
			dev_q <= key_dev;
			blk_q <= key_blk;
		end
	end

	// Tag compare, valid slots only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (look_en) begin
			match_q <= !flags_q[bbc_pkg::FB_INVAL] && dev_q == key_dev && blk_q == key_blk;
		end
	end

	// Lowest index wins
	assign seen_out = seen_in | match_q;
	assign first    = match_q & !seen_in;
	assign flags    = flags_q;
	assign tag_dev  = dev_q;
	assign tag_blk  = blk_q;

endmodule

>>> design/bbc_list_cell.sv
module bbc_list_cell #(
	parameter int SW  = 5,
	parameter int CW  = 6,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  bbc_pkg::lop_t lop,
	input  logic [CW-1:0] count,
	input  logic [SW-1:0] slot,
	input  logic [SW-1:0] left,
	input  logic [SW-1:0] right,
	input  logic          found_in,
	output logic          found_out,
	output logic [SW-1:0] entry
);

	logic [SW-1:0] entry_q;
	logic          live;
	logic          hit;

	assign live      = CW'(IDX) < count;
	assign hit       = live && entry_q == slot;
	assign found_out = found_in | hit;

	// One free list position; shifts with its neighbours
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= SW'(IDX);
		end else if (en) begin
			case (lop)
				bbc_pkg::LOP_TAKE: if (live && found_out) entry_q <= right;
				bbc_pkg::LOP_HEAD: entry_q <= left;
				bbc_pkg::LOP_TAIL: if (count == CW'(IDX)) entry_q <= slot;
				default: ;
			endcase
		end
	end

	assign entry = entry_q;

endmodule

>>> design/block_buffer_cache_lru_core.sv
// Channel | Signals                       | Payload
// request | req_valid, req_ready, req     | bbc_pkg::req_t
// result  | rsp_valid, rsp_ready, rsp     | bbc_pkg::rsp_t
//
// Each request goes through accept, tag compare in every slot cell,
// decision from the registered match vector, then update of the slot cells
// and the free list chain. The update waits while a previous result is held.
// After reset all slots are invalid and on the free list in index order.
module block_buffer_cache_lru_core #(
	parameter int NUM_BUFFERS = bbc_pkg::NUM_BUFFERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bbc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bbc_pkg::rsp_t rsp
);

	localparam int SW = $clog2(NUM_BUFFERS);
	localparam int CW = $clog2(NUM_BUFFERS + 1);
	localparam int FW = bbc_pkg::FLAG_W;

	bbc_pkg::state_t    state_q, state_d;
	bbc_pkg::req_t      req_q;
	logic [CW-1:0]      count_q;
	logic               rsp_valid_q;
	bbc_pkg::rsp_t      rsp_q, pend_q, pend_d;
	bbc_pkg::flag_upd_t upd_q, upd_d;
	bbc_pkg::lop_t      lop_q, lop_d;
	logic [SW-1:0]      act_slot_q, act_slot_d;

	logic look_en, apply_en;

	logic [FW-1:0]    flags_all [NUM_BUFFERS];
	logic [15:0]      tdev_all  [NUM_BUFFERS];
	logic [30:0]      tblk_all  [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] first_v;
	logic [NUM_BUFFERS:0]   seen_c;
	logic [SW-1:0]    entry_all [NUM_BUFFERS];
	logic [NUM_BUFFERS:0]   found_c;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bbc_pkg::S_IDLE:   if (req_valid) state_d = bbc_pkg::S_LOOK;
			bbc_pkg::S_LOOK:   state_d = bbc_pkg::S_DECIDE;
			bbc_pkg::S_DECIDE: state_d = bbc_pkg::S_APPLY;
			bbc_pkg::S_APPLY:  if (!rsp_valid_q || rsp_ready) state_d = bbc_pkg::S_IDLE;
			default:           state_d = bbc_pkg::S_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		req_ready = state_q == bbc_pkg::S_IDLE;
		look_en   = state_q == bbc_pkg::S_LOOK;
		apply_en  = state_q == bbc_pkg::S_APPLY && (!rsp_valid_q || rsp_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) req_q <= req;
	end

	// Slot cells
	assign seen_c[0] = 1'b0;
	generate
		for (genvar i = 0; i < NUM_BUFFERS; i++) begin : g_slot
			bbc_slot_cell #(.SW(SW), .IDX(i)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.look_en  (look_en),
				.key_dev  (req_q.device_id),
				.key_blk  (req_q.block_number),
				.upd_en   (apply_en),
				.upd_slot (act_slot_q),
				.upd      (upd_q),
				.seen_in  (seen_c[i]),
				.seen_out (seen_c[i+1]),
				.first    (first_v[i]),
				.flags    (flags_all[i]),
				.tag_dev  (tdev_all[i]),
				.tag_blk  (tblk_all[i])
			);
		end
	endgenerate

	// Free list cells
	assign found_c[0] = 1'b0;
	generate
		for (genvar i = 0; i < NUM_BUFFERS; i++) begin : g_list
			logic [SW-1:0] left_w, right_w;
			if (i == 0) begin : g_l0
				assign left_w = act_slot_q;
			end else begin : g_ln
				assign left_w = entry_all[i-1];
			end
			if (i == NUM_BUFFERS - 1) begin : g_rl
				assign right_w = entry_all[i];
			end else begin : g_rn
				assign right_w = entry_all[i+1];
			end
			bbc_list_cell #(.SW(SW), .CW(CW), .IDX(i)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (apply_en),
				.lop       (lop_q),
				.count     (count_q),
				.slot      (act_slot_q),
				.left      (left_w),
				.right     (right_w),
				.found_in  (found_c[i]),
				.found_out (found_c[i+1]),
				.entry     (entry_all[i])
			);
		end
	endgenerate

	// Decision from the registered match vector
	always_comb begin
		logic [SW-1:0] hit_idx, head, sidx;
		logic [15:0]   vdev;
		logic [30:0]   vblk;
		logic [FW-1:0] f, nf;
		logic          in_range;
		hit_idx = '0;
		vdev    = '0;
		vblk    = '0;
		head    = entry_all[0];
		for (int i = 0; i < NUM_BUFFERS; i++) begin
			if (first_v[i]) hit_idx = hit_idx | SW'(i);
			if (head == SW'(i)) begin
				vdev = vdev | tdev_all[i];
				vblk = vblk | tblk_all[i];
			end
		end
		sidx     = SW'(req_q.slot_index);
		in_range = 9'(req_q.slot_index) < 9'(NUM_BUFFERS);
		upd_d    = '0;
		lop_d    = bbc_pkg::LOP_NONE;
		act_slot_d = sidx;
		pend_d   = '0;
		pend_d.status       = bbc_pkg::ST_DONE;
		pend_d.granted_slot = req_q.slot_index;
		f  = '0;
		nf = '0;
		if (req_q.operation == bbc_pkg::OP_GET) begin
			if (seen_c[NUM_BUFFERS]) begin
				f = flags_all[hit_idx];
				act_slot_d = hit_idx;
				pend_d.granted_slot = 5'(hit_idx);
				pend_d.data_valid = f[bbc_pkg::FB_DONE] | f[bbc_pkg::FB_DIRTY];
				if (f[bbc_pkg::FB_BUSY]) begin
					pend_d.status = bbc_pkg::ST_BUSY;
				end else begin
					pend_d.status = bbc_pkg::ST_HIT;
					lop_d = bbc_pkg::LOP_TAKE;
					upd_d.flag_we = 1'b1;
					upd_d.flags = f | bbc_pkg::FLAGS_BUSY;
				end
			end else if (count_q == '0) begin
				pend_d.status = bbc_pkg::ST_NOFREE;
				pend_d.granted_slot = '0;
			end else begin
				f = flags_all[head];
				act_slot_d = head;
				pend_d.granted_slot = 5'(head);
				lop_d = bbc_pkg::LOP_TAKE;
				upd_d.flag_we = 1'b1;
				if (f[bbc_pkg::FB_DIRTY]) begin
					upd_d.flags = f | bbc_pkg::FLAGS_BUSY;
					pend_d.status = bbc_pkg::ST_WRITEBACK;
					pend_d.data_valid = 1'b1;
					pend_d.victim_device = vdev;
					pend_d.victim_block = vblk;
				end else begin
					upd_d.flags = bbc_pkg::FLAGS_BUSY;
					upd_d.tag_we = 1'b1;
					pend_d.status = bbc_pkg::ST_MISS;
				end
			end
		end else if (req_q.operation <= bbc_pkg::OP_WRITE_DONE && in_range &&
				flags_all[sidx][bbc_pkg::FB_BUSY]) begin
			f  = flags_all[sidx];
			nf = f;
			case (req_q.operation)
				bbc_pkg::OP_READ_DONE: begin
					nf[bbc_pkg::FB_INVAL] = 1'b0;
					nf[bbc_pkg::FB_READ]  = 1'b1;
					nf[bbc_pkg::FB_DONE]  = 1'b1;
				end
				bbc_pkg::OP_DELAYED_WR: begin
					nf[bbc_pkg::FB_DONE]  = 1'b0;
					nf[bbc_pkg::FB_DIRTY] = 1'b1;
					nf[bbc_pkg::FB_BUSY]  = 1'b0;
				end
				bbc_pkg::OP_WRITE_DONE: begin
					nf[bbc_pkg::FB_READ]  = 1'b0;
					nf[bbc_pkg::FB_DIRTY] = 1'b0;
					nf[bbc_pkg::FB_DONE]  = 1'b1;
					nf[bbc_pkg::FB_BUSY]  = 1'b0;
				end
				default: nf[bbc_pkg::FB_BUSY] = 1'b0;
			endcase
			upd_d.flag_we = 1'b1;
			upd_d.flags   = nf;
			pend_d.data_valid = nf[bbc_pkg::FB_DONE] | nf[bbc_pkg::FB_DIRTY];
			// Released slots go back on the list, invalid ones at the head
			if (req_q.operation != bbc_pkg::OP_READ_DONE &&
					count_q < CW'(NUM_BUFFERS)) begin
				lop_d = nf[bbc_pkg::FB_INVAL] ? bbc_pkg::LOP_HEAD : bbc_pkg::LOP_TAIL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_q <= '0;
			lop_q <= bbc_pkg::LOP_NONE;
		end else if (state_q == bbc_pkg::S_DECIDE) begin
			upd_q <= upd_d;
			lop_q <= lop_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bbc_pkg::S_DECIDE) begin
			pend_q     <= pend_d;
			act_slot_q <= act_slot_d;
		end
	end

	// Free count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(NUM_BUFFERS);
		end else if (apply_en) begin
			case (lop_q)
				bbc_pkg::LOP_TAKE: count_q <= count_q - 1'b1;
				bbc_pkg::LOP_HEAD, bbc_pkg::LOP_TAIL: count_q <= count_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (apply_en) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_en) rsp_q <= pend_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(NUM_BUFFERS))
		else $error("free count above cache size");

	a_take_dec: assert property (@(posedge clk) disable iff (!arst_n)
		apply_en && lop_q == bbc_pkg::LOP_TAKE |=> count_q == $past(count_q) - 1'b1)
		else $error("take did not shorten free list");

	a_take_found: assert property (@(posedge clk) disable iff (!arst_n)
		apply_en && lop_q == bbc_pkg::LOP_TAKE |-> found_c[NUM_BUFFERS])
		else $error("taken slot not on free list");

	a_one_first: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bbc_pkg::S_DECIDE |-> $onehot0(first_v))
		else $error("several first matches");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(apply_en))
		else $error("result without update");

endmodule

>>> verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBUF = 32;
	localparam int LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	bbc_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	bbc_pkg::rsp_t rsp;

	block_buffer_cache_lru_core #(.NUM_BUFFERS(NBUF)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// Predicted cache state
	logic [15:0]                c_dev [NBUF];
	logic [30:0]                c_blk [NBUF];
	logic [bbc_pkg::FLAG_W-1:0] c_flags [NBUF];
	int                         c_lru [$];

	bbc_pkg::req_t pending_reqs [$];
	bbc_pkg::rsp_t expected_rsps [$];
	int   errors = 0;
	int   cycles = 0;
	bit   stim_done = 0;
	bit   calm = 0;
	int   in_gap = 0, out_gap = 0;

	// Tags the host has used, reused to get hits
	logic [15:0] used_dev [$];
	logic [30:0] used_blk [$];

	function automatic void lru_take(int s);
		foreach (c_lru[i])
			if (c_lru[i] == s) begin
				c_lru.delete(i);
				return;
			end
	endfunction

	function automatic void slot_release(int s);
		c_flags[s][bbc_pkg::FB_BUSY] = 1'b0;
		foreach (c_lru[i]) if (c_lru[i] == s) return;
		if (c_flags[s][bbc_pkg::FB_INVAL]) c_lru.push_front(s);
		else c_lru.push_back(s);
	endfunction

	// Work out the result of one request and advance the cache state
	function automatic bbc_pkg::rsp_t cache_predict(bbc_pkg::req_t r);
		bbc_pkg::rsp_t o;
		int hit, v;
		o = '0;
		o.status = bbc_pkg::ST_DONE;
		o.granted_slot = r.slot_index;
		if (r.operation == bbc_pkg::OP_GET) begin
			hit = -1;
			for (int i = 0; i < NBUF; i++)
				if (hit < 0 && !c_flags[i][bbc_pkg::FB_INVAL] &&
						c_dev[i] == r.device_id && c_blk[i] == r.block_number)
					hit = i;
			if (hit >= 0) begin
				o.granted_slot = 5'(hit);
				if (c_flags[hit][bbc_pkg::FB_BUSY]) o.status = bbc_pkg::ST_BUSY;
				else begin
					lru_take(hit);
					c_flags[hit][bbc_pkg::FB_BUSY] = 1'b1;
					o.status = bbc_pkg::ST_HIT;
				end
				o.data_valid = c_flags[hit][bbc_pkg::FB_DONE] |
					c_flags[hit][bbc_pkg::FB_DIRTY];
			end else if (c_lru.size() == 0) begin
				o.status = bbc_pkg::ST_NOFREE;
				o.granted_slot = '0;
			end else begin
				v = c_lru.pop_front();
				o.granted_slot = 5'(v);
				if (c_flags[v][bbc_pkg::FB_DIRTY]) begin
					c_flags[v][bbc_pkg::FB_BUSY] = 1'b1;
					o.status = bbc_pkg::ST_WRITEBACK;
					o.data_valid = c_flags[v][bbc_pkg::FB_DONE] |
						c_flags[v][bbc_pkg::FB_DIRTY];
					o.victim_device = c_dev[v];
					o.victim_block = c_blk[v];
				end else begin
					c_flags[v] = bbc_pkg::FLAGS_BUSY;
					c_dev[v] = r.device_id;
					c_blk[v] = r.block_number;
					o.status = bbc_pkg::ST_MISS;
				end
			end
		end else if (r.operation <= bbc_pkg::OP_WRITE_DONE && r.slot_index < NBUF &&
				c_flags[r.slot_index][bbc_pkg::FB_BUSY]) begin
			v = int'(r.slot_index);
			case (r.operation)
				bbc_pkg::OP_READ_DONE: begin
					c_flags[v][bbc_pkg::FB_INVAL] = 1'b0;
					c_flags[v][bbc_pkg::FB_READ] = 1'b1;
					c_flags[v][bbc_pkg::FB_DONE] = 1'b1;
				end
				bbc_pkg::OP_DELAYED_WR: begin
					c_flags[v][bbc_pkg::FB_DONE] = 1'b0;
					c_flags[v][bbc_pkg::FB_DIRTY] = 1'b1;
					slot_release(v);
				end
				bbc_pkg::OP_WRITE_DONE: begin
					c_flags[v][bbc_pkg::FB_READ] = 1'b0;
					c_flags[v][bbc_pkg::FB_DIRTY] = 1'b0;
					c_flags[v][bbc_pkg::FB_DONE] = 1'b1;
					slot_release(v);
				end
				default: slot_release(v);
			endcase
			o.data_valid = c_flags[v][bbc_pkg::FB_DONE] | c_flags[v][bbc_pkg::FB_DIRTY];
		end
		return o;
	endfunction

	function automatic bbc_pkg::req_t make_req(logic [2:0] op, logic [15:0] d,
			logic [30:0] b, logic [4:0] s);
		bbc_pkg::req_t r;
		r.operation = op;
		r.device_id = d;
		r.block_number = b;
		r.slot_index = s;
		return r;
	endfunction

	// Get with a tag that is fresh or was used before
	function automatic bbc_pkg::req_t rand_get();
		int k;
		if (used_dev.size() > 0 && $urandom_range(0, 99) < 60) begin
			k = $urandom_range(0, used_dev.size() - 1);
			return make_req(bbc_pkg::OP_GET, used_dev[k], used_blk[k], 5'($urandom()));
		end
		if ($urandom_range(0, 3) == 0)
			return make_req(bbc_pkg::OP_GET, 16'($urandom()), 31'($urandom()),
				5'($urandom()));
		return make_req(bbc_pkg::OP_GET, 16'($urandom_range(0, 3)),
			31'($urandom_range(0, 40)), 5'($urandom()));
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Request stimulus
	initial begin
		bbc_pkg::req_t r;
		logic [4:0] s;
		int n;
		arst_n = 1'b0;
		// Directed: extremes, every operation, special cases
		pending_reqs.push_back(make_req(bbc_pkg::OP_RELEASE, 16'h0, 31'h0, 5'd0));
		pending_reqs.push_back(make_req(3'd5, 16'hffff, 31'h7fffffff, 5'd31));
		pending_reqs.push_back(make_req(3'd7, 16'h0, 31'h0, 5'd17));
		pending_reqs.push_back(make_req(bbc_pkg::OP_GET, 16'hffff, 31'h7fffffff, 5'd31));
		pending_reqs.push_back(make_req(bbc_pkg::OP_GET, 16'hffff, 31'h7fffffff, 5'd0));
		pending_reqs.push_back(make_req(bbc_pkg::OP_READ_DONE, 16'h0, 31'h0, 5'd0));
		pending_reqs.push_back(make_req(bbc_pkg::OP_DELAYED_WR, 16'h0, 31'h0, 5'd0));
		pending_reqs.push_back(make_req(bbc_pkg::OP_GET, 16'hffff, 31'h7fffffff, 5'd0));
		pending_reqs.push_back(make_req(bbc_pkg::OP_WRITE_DONE, 16'h0, 31'h0, 5'd0));
		pending_reqs.push_back(make_req(bbc_pkg::OP_GET, 16'h0, 31'h0, 5'd0));
		pending_reqs.push_back(make_req(bbc_pkg::OP_GET, 16'h0, 31'h0, 5'd0));
		pending_reqs.push_back(make_req(bbc_pkg::OP_RELEASE, 16'h0, 31'h0, 5'd1));
		pending_reqs.push_back(make_req(bbc_pkg::OP_DELAYED_WR, 16'h0, 31'h0, 5'd2));
		// Fill the cache, then miss with nothing free
		for (int i = 0; i < 33; i++)
			pending_reqs.push_back(make_req(bbc_pkg::OP_GET, 16'h1234, 31'(1000 + i),
				5'd0));
		pending_reqs.push_back(make_req(bbc_pkg::OP_WRITE_DONE, 16'h0, 31'h0, 5'd5));
		used_dev.push_back(16'hffff);
		used_blk.push_back(31'h7fffffff);
		used_dev.push_back(16'h0);
		used_blk.push_back(31'h0);
		// Random: mostly get/read/release sequences, some noise
		n = 0;
		while (n < 1700) begin
			r = rand_get();
			if (used_dev.size() < 64) begin
				used_dev.push_back(r.device_id);
				used_blk.push_back(r.block_number);
			end
			pending_reqs.push_back(r);
			n++;
			s = 5'($urandom());
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					pending_reqs.push_back(make_req(bbc_pkg::OP_READ_DONE,
						16'($urandom()), 31'($urandom()), s));
					n++;
				end
				3: begin
					pending_reqs.push_back(make_req(3'($urandom_range(5, 7)),
						16'($urandom()), 31'($urandom()), s));
					n++;
				end
				default: ;
			endcase
			r = make_req(3'($urandom_range(bbc_pkg::OP_RELEASE, bbc_pkg::OP_WRITE_DONE)),
				16'($urandom()), 31'($urandom()), 5'($urandom()));
			pending_reqs.push_back(r);
			n++;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0);
		stim_done = 1'b1;
	end

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready) begin
				expected_rsps.push_back(cache_predict(req));
				pending_reqs.pop_front();
			end
			if (pending_reqs.size() < 300) calm <= 1'b1;
			if (req_valid && !req_ready) begin
				// hold
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				req_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				in_gap <= $urandom_range(1, 16) - 1;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > ((req_valid && req_ready) ? 0 : 0)) begin
				req_valid <= 1'b1;
				req <= pending_reqs[0];
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			rsp_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			out_gap <= $urandom_range(1, 16) - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		bbc_pkg::rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected result %h", $time, rsp);
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.status !== e.status)
					$display("%0t: status exp %0d got %0d", $time, e.status, rsp.status);
				if (rsp.granted_slot !== e.granted_slot)
					$display("%0t: granted_slot exp %0d got %0d", $time, e.granted_slot,
						rsp.granted_slot);
				if (rsp.data_valid !== e.data_valid)
					$display("%0t: data_valid exp %0d got %0d", $time, e.data_valid,
						rsp.data_valid);
				if (rsp.victim_device !== e.victim_device)
					$display("%0t: victim_device exp %h got %h", $time, e.victim_device,
						rsp.victim_device);
				if (rsp.victim_block !== e.victim_block)
					$display("%0t: victim_block exp %h got %h", $time, e.victim_block,
						rsp.victim_block);
				if (rsp !== e) errors++;
			end
		end
	end

	// Cache model reset and run end
	initial begin
		for (int i = 0; i < NBUF; i++) begin
			c_dev[i] = '0;
			c_blk[i] = '0;
			c_flags[i] = bbc_pkg::FLAGS_RESET;
			c_lru.push_back(i);
		end
		wait (stim_done && !req_valid && expected_rsps.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule
